/* rtl/vfpe_pkg.sv */
`default_nettype none
package vfpe_pkg;

  // field widths
  localparam int ValW   = 32;
  localparam int MW     = 50;
  localparam int MagW   = 50;
  localparam int ScW    = 30;
  localparam int SumW   = 64;
  localparam int LenW   = 32;
  localparam int QW     = 31;
  localparam int PlaneW = 3;

  localparam logic [PlaneW-1:0] LastPlane = 3'd5;

  // input word kinds
  localparam logic [1:0] ModeLoadProj = 2'd0;
  localparam logic [1:0] ModeLoadView = 2'd1;
  localparam logic [1:0] ModeCompute  = 2'd2;

  // matrix row combined with row 3 for a plane
  function automatic logic [1:0] plane_row(input logic [PlaneW-1:0] p);
    logic [1:0] r;
    case (p) inside
      3'd0, 3'd1: r = 2'd0;
      3'd2, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

  // plane takes row 3 minus the row
  function automatic logic plane_neg(input logic [PlaneW-1:0] p);
    logic n;
    case (p) inside
      3'd1, 3'd2, 3'd5: n = 1'b1;
      default:          n = 1'b0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

/* rtl/vfpe_isqrt.sv */
`default_nettype none
module vfpe_isqrt
  import vfpe_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [SumW-1:0] radicand_i,
  output logic                 done_o,
  output logic [LenW-1:0]      root_o
);

  logic            busy_q, done_q;
  logic [SumW-1:0] rem_q, res_q, bit_q;
  logic [SumW-1:0] trial;

  assign trial = res_q + bit_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q == 64'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // one result bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= radicand_i;
      res_q <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[LenW-1:0];

endmodule
`default_nettype wire

/* rtl/vfpe_div.sv */
`default_nettype none
module vfpe_div
  import vfpe_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [ScW-1:0]  num_i,
  input  wire logic [LenW-1:0] den_i,
  output logic                 done_o,
  output logic [QW-1:0]        quot_o
);

  logic            busy_q, done_q;
  logic [4:0]      cnt_q;
  logic [LenW-1:0] rem_q, den_q;
  logic [QW-1:0]   q_q;
  logic [LenW:0]   shifted;
  logic [LenW-1:0] num_ext;

  assign shifted = {rem_q, 1'b0};
  assign num_ext = {{(LenW-ScW){1'b0}}, num_i};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(ScW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division of num * 2^30 by den, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      if (num_ext >= den_i) begin
        rem_q <= num_ext - den_i;
        q_q   <= QW'(1);
      end else begin
        rem_q <= num_ext;
        q_q   <= '0;
      end
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_q <= LenW'(shifted - {1'b0, den_q});
        q_q   <= {q_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[LenW-1:0];
        q_q   <= {q_q[QW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule
`default_nettype wire

/* rtl/view_frustum_plane_extractor_core.sv */
// channel   dir  signals                     word
// s_axis    in   tvalid tready tdata[39:0]   mode, row, col, value
// m_axis    out  tvalid tready tdata[135:0]  plane, coef_a..coef_d; tuser degenerate;
//                tlast                       tlast on the sixth plane
// load words are taken whenever the core is idle and may come back to back.
// a compute word runs the matrix product on the one 32x32 multiplier, then per
// plane the 32-step square root and four 31-step divisions, the divisions
// skipped when the length is zero. s_axis_tready_o is low for the whole compute.
// a plane waits in the output register while the next one is worked out; the
// sequencer holds when that register is still full and not being taken. reset clears control only.
`default_nettype none
module view_frustum_plane_extractor_core
  import vfpe_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [39:0]  s_axis_tdata_i,   // mode[1:0] row[3:2] col[5:4] value[37:6]
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [135:0]      m_axis_tdata_o,   // plane[2:0] a[34:3] b[66:35] c[98:67] d[130:99]
  output logic [0:0]        m_axis_tuser_o,   // degenerate[0]
  output logic              m_axis_tlast_o
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_MUL  = 11'b000_0000_0010,
    S_ACC  = 11'b000_0000_0100,
    S_RD3  = 11'b000_0000_1000,
    S_RDR  = 11'b000_0001_0000,
    S_NORM = 11'b000_0010_0000,
    S_SQ   = 11'b000_0100_0000,
    S_SQRT = 11'b000_1000_0000,
    S_DIV  = 11'b001_0000_0000,
    S_DIVW = 11'b010_0000_0000,
    S_EMIT = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // input fields
  logic [1:0]             in_mode, in_row, in_col;
  logic signed [ValW-1:0] in_value;
  logic                   in_acc;

  assign in_mode  = s_axis_tdata_i[1:0];
  assign in_row   = s_axis_tdata_i[3:2];
  assign in_col   = s_axis_tdata_i[5:4];
  assign in_value = s_axis_tdata_i[37:6];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // matrix stores
  logic signed [ValW-1:0] proj_q [16];
  logic signed [ValW-1:0] view_q [16];
  logic signed [MW-1:0]   m_q    [16];

  always_ff @(posedge clk_i) begin
    if (in_acc && in_mode == ModeLoadProj) proj_q[{in_row, in_col}] <= in_value;
    if (in_acc && in_mode == ModeLoadView) view_q[{in_row, in_col}] <= in_value;
  end

  // sequencer registers
  logic [1:0]             r_q, r_d, c_q, c_d, k_q, k_d, comp_q, comp_d;
  logic [PlaneW-1:0]      plane_q, plane_d;
  logic signed [63:0]     prod_q, prod_d;
  logic signed [MW-1:0]   acc_q, acc_d, tmp_q, tmp_d;
  logic [3:0]             neg_q, neg_d;
  logic [MagW-1:0]        mag_q [4];
  logic [MagW-1:0]        mag_d [4];
  logic [MagW-1:0]        maxm_q, maxm_d;
  logic [SumW-1:0]        sum_q, sum_d;
  logic [LenW-1:0]        len_q, len_d;
  logic [QW-1:0]          q_q [4];
  logic [QW-1:0]          q_d [4];

  // output register
  logic                   ov_q, ov_d;
  logic [135:0]           od_q, od_d;
  logic                   odeg_q, odeg_d, olast_q, olast_d;

  // shared units
  logic                   sqrt_start, sqrt_done, div_start, div_done;
  logic [LenW-1:0]        root;
  logic [QW-1:0]          quot;

  vfpe_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sum_d),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  vfpe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (mag_q[comp_q][ScW-1:0]),
    .den_i  (len_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  // datapath terms
  logic signed [63:0]     prod_adj;
  logic signed [47:0]     prod_tr;
  logic signed [MW-1:0]   acc_new;
  logic signed [MW:0]     va, vb, vsum, vabs;
  logic [59:0]            sq;
  logic                   m_we;
  logic [3:0]             m_waddr;
  logic [31:0]            coef [4];

  assign prod_adj = prod_q + (prod_q[63] ? 64'sd65535 : 64'sd0);
  assign prod_tr  = prod_adj[63:16];
  assign acc_new  = acc_q + {{(MW-48){prod_tr[47]}}, prod_tr};
  assign va   = {tmp_q[MW-1], tmp_q};
  assign vb   = {m_q[{plane_row(plane_q), comp_q}][MW-1], m_q[{plane_row(plane_q), comp_q}]};
  assign vsum = plane_neg(plane_q) ? va - vb : va + vb;
  assign vabs = vsum[MW] ? -vsum : vsum;
  assign sq   = mag_q[comp_q][ScW-1:0] * mag_q[comp_q][ScW-1:0];

  // signed coefficients
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      coef[i] = neg_q[i] ? -{1'b0, q_q[i]} : {1'b0, q_q[i]};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    r_d = r_q; c_d = c_q; k_d = k_q; comp_d = comp_q; plane_d = plane_q;
    prod_d = prod_q; acc_d = acc_q; tmp_d = tmp_q; neg_d = neg_q;
    mag_d = mag_q; maxm_d = maxm_q; sum_d = sum_q; len_d = len_q; q_d = q_q;
    ov_d = ov_q; od_d = od_q; odeg_d = odeg_q; olast_d = olast_q;
    sqrt_start = 1'b0; div_start = 1'b0;
    m_we = 1'b0; m_waddr = {r_q, c_q};

    if (ov_q && m_axis_tready_i) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_mode == ModeCompute) begin
          r_d = '0; c_d = '0; k_d = '0; acc_d = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = proj_q[{r_q, k_q}] * view_q[{k_q, c_q}];
        state_d = S_ACC;
      end
      S_ACC: begin
        if (k_q == 2'd3) begin
          m_we  = 1'b1;
          acc_d = '0;
          k_d   = '0;
          c_d   = c_q + 2'd1;
          if (c_q == 2'd3) r_d = r_q + 2'd1;
          if (r_q == 2'd3 && c_q == 2'd3) begin
            plane_d = '0; comp_d = '0;
            state_d = S_RD3;
          end else begin
            state_d = S_MUL;
          end
        end else begin
          acc_d   = acc_new;
          k_d     = k_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_RD3: begin
        tmp_d   = m_q[{2'd3, comp_q}];
        state_d = S_RDR;
      end
      S_RDR: begin
        neg_d[comp_q] = vsum[MW];
        mag_d[comp_q] = vabs[MagW-1:0];
        if (comp_q == 2'd0 || vabs[MagW-1:0] > maxm_q) maxm_d = vabs[MagW-1:0];
        comp_d = comp_q + 2'd1;
        state_d = (comp_q == 2'd3) ? S_NORM : S_RD3;
      end
      S_NORM: begin
        if (maxm_q[MagW-1:ScW] != '0) begin
          maxm_d = maxm_q >> 1;
          for (int i = 0; i < 4; i++) mag_d[i] = mag_q[i] >> 1;
        end else begin
          sum_d = '0; comp_d = '0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        sum_d  = sum_q + {{(SumW-60){1'b0}}, sq};
        comp_d = comp_q + 2'd1;
        if (comp_q == 2'd3) begin
          sqrt_start = 1'b1;
          state_d    = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          len_d = root; comp_d = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (len_q == '0) begin
          q_d[comp_q] = '0;
          comp_d = comp_q + 2'd1;
          if (comp_q == 2'd3) state_d = S_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          q_d[comp_q] = quot;
          comp_d  = comp_q + 2'd1;
          state_d = (comp_q == 2'd3) ? S_EMIT : S_DIV;
        end
      end
      S_EMIT: begin
        if (!ov_q || m_axis_tready_i) begin
          ov_d    = 1'b1;
          od_d    = {5'b0, coef[3], coef[2], coef[1], coef[0], plane_q};
          odeg_d  = (len_q == '0);
          olast_d = (plane_q == LastPlane);
          comp_d  = '0;
          if (plane_q == LastPlane) begin
            state_d = S_IDLE;
          end else begin
            plane_d = plane_q + 3'd1;
            state_d = S_RD3;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    r_q <= r_d; c_q <= c_d; k_q <= k_d; comp_q <= comp_d; plane_q <= plane_d;
    prod_q <= prod_d; acc_q <= acc_d; tmp_q <= tmp_d; neg_q <= neg_d;
    mag_q <= mag_d; maxm_q <= maxm_d; sum_q <= sum_d; len_q <= len_d; q_q <= q_d;
    od_q <= od_d; odeg_q <= odeg_d; olast_q <= olast_d;
    if (m_we) m_q[m_waddr] <= acc_new;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;
  assign m_axis_tuser_o  = odeg_q;
  assign m_axis_tlast_o  = olast_q;

endmodule
`default_nettype wire
